@@ rtl/core/bary_pkg.sv @@
`timescale 1ns / 1ps

package bary_pkg;

  // coordinate and weight formats
  localparam int COORD_BITS       = 16;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WEIGHT_BITS      = WEIGHT_FRAC_BITS + 4;

  // datapath widths
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = CROSS_W;
  localparam int NUM_W   = MAG_W + WEIGHT_FRAC_BITS + 2;
  localparam int DEN_W   = MAG_W + 1;
  localparam int CMP_W   = DEN_W + WEIGHT_BITS;

  // one quotient bit per divider stage, top bit flags overflow
  localparam int DIV_STEPS   = WEIGHT_BITS + 1;
  localparam int PIPE_STAGES = 4 + DIV_STEPS;
  localparam int LANES       = 3;

  // stream packing
  localparam int IN_W       = 2 * COORD_BITS;
  localparam int S_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W      = LANES * WEIGHT_BITS;
  localparam int M_TDATA_W  = ((OUT_W + 7) / 8) * 8;

  // configuration registers
  localparam int NUM_REGS  = 6;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_VERT0_X = 3'd0,
    REG_VERT0_Y = 3'd1,
    REG_VERT1_X = 3'd2,
    REG_VERT1_Y = 3'd3,
    REG_VERT2_X = 3'd4,
    REG_VERT2_Y = 3'd5
  } reg_idx_t;

  // saturation limits of a weight
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX =
    WEIGHT_BITS'((64'd1 << (WEIGHT_BITS - 1)) - 64'd1);
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MIN =
    WEIGHT_BITS'(64'd1 << (WEIGHT_BITS - 1));

  typedef struct packed {
    logic                   degenerate;
    logic [WEIGHT_BITS-1:0] weight_c;
    logic [WEIGHT_BITS-1:0] weight_b;
    logic [WEIGHT_BITS-1:0] weight_a;
  } result_t;

  // rounded quotient magnitude plus sign to a saturated weight
  function automatic logic [WEIGHT_BITS-1:0] sat_weight(
    input logic [DIV_STEPS-1:0] q,
    input logic                 neg
  );
    logic                   ovf;
    logic [WEIGHT_BITS-1:0] qm;
    logic [WEIGHT_BITS-1:0] w;
    ovf = q[DIV_STEPS-1];
    qm  = q[WEIGHT_BITS-1:0];
    if (q == '0) begin
      w = '0;
    end else if (neg) begin
      w = (ovf || qm > WEIGHT_MIN) ? WEIGHT_MIN : WEIGHT_BITS'(-qm);
    end else begin
      w = (ovf || qm > WEIGHT_MAX) ? WEIGHT_MAX : qm;
    end
    return w;
  endfunction

endpackage

@@ rtl/core/barycentric_coords_top.sv @@
`timescale 1ns / 1ps

// Barycentric weights of a query point against a fixed triangle.
// Vertices are written through the cfg port (cfg_we, cfg_index 0..5 for
// vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, signed 12.4);
// write them only while no transaction is in flight. Indexes 6 and 7
// are ignored. Each transaction on the s side carries one point, each
// transaction on the m side one result: three signed Q3.16 weights,
// rounded to nearest and saturated, plus a degenerate flag in m_tuser
// that is set, with all weights zero, when the triangle has no area.
// Throughput is one point per clock while s_tready is high. The pipeline
// is one stage of edge differences, one of 17x17 multipliers, one
// cross product subtract, one setup stage and a 21-stage restoring
// divider (one quotient bit per stage, the top bit catching overflow),
// three lanes wide and sharing one divisor.
// When m_tready is low the output register holds and a skid register
// takes one more result; then s_tready drops and the pipeline freezes
// without losing or repeating anything. Reset (rst, synchronous) empties
// the pipeline and clears all vertices to zero.
module barycentric_coords_top (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [bary_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [bary_pkg::COORD_BITS-1:0]    cfg_data,
  // points in
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [bary_pkg::S_TDATA_W-1:0]     s_tdata,   // point_x, point_y
  // weights out
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bary_pkg::M_TDATA_W-1:0]     m_tdata,   // weight_a, weight_b, weight_c
  output logic                               m_tuser    // degenerate
);

  localparam int CW = bary_pkg::COORD_BITS;
  localparam int DW = bary_pkg::DIFF_W;
  localparam int PW = bary_pkg::PROD_W;
  localparam int XW = bary_pkg::CROSS_W;
  localparam int NS = bary_pkg::DIV_STEPS;
  localparam int NL = bary_pkg::LANES;

  // vertex registers
  logic signed [CW-1:0] vert [bary_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bary_pkg::NUM_REGS; i++) begin
        vert[i] <= '0;
      end
    end else if (cfg_we && cfg_index < bary_pkg::REG_IDX_W'(bary_pkg::NUM_REGS)) begin
      vert[cfg_index] <= cfg_data;
    end
  end

  // pipeline control: stages move together unless the skid register is full
  logic                            en;
  logic [bary_pkg::PIPE_STAGES-1:0] vld;
  logic                            push;
  logic                            out_vld;
  logic                            skid_vld;

  assign en       = !skid_vld;
  assign s_tready = en;
  assign push     = en && vld[bary_pkg::PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[bary_pkg::PIPE_STAGES-2:0], s_tvalid};
    end
  end

  // stage 1: edge vectors and vectors from the point
  logic signed [CW-1:0] pt_x;
  logic signed [CW-1:0] pt_y;
  logic signed [DW-1:0] e1x, e1y, e2x, e2y;   // v1-v0, v2-v0
  logic signed [DW-1:0] ax, ay, bx, by;       // v1-p, v2-p
  logic signed [DW-1:0] dx, dy;               // p-v0

  assign pt_x = s_tdata[CW-1:0];
  assign pt_y = s_tdata[2*CW-1:CW];

  always_ff @(posedge clk) begin
    if (en) begin
      e1x <= DW'(vert[bary_pkg::REG_VERT1_X]) - DW'(vert[bary_pkg::REG_VERT0_X]);
      e1y <= DW'(vert[bary_pkg::REG_VERT1_Y]) - DW'(vert[bary_pkg::REG_VERT0_Y]);
      e2x <= DW'(vert[bary_pkg::REG_VERT2_X]) - DW'(vert[bary_pkg::REG_VERT0_X]);
      e2y <= DW'(vert[bary_pkg::REG_VERT2_Y]) - DW'(vert[bary_pkg::REG_VERT0_Y]);
      ax  <= DW'(vert[bary_pkg::REG_VERT1_X]) - DW'(pt_x);
      ay  <= DW'(vert[bary_pkg::REG_VERT1_Y]) - DW'(pt_y);
      bx  <= DW'(vert[bary_pkg::REG_VERT2_X]) - DW'(pt_x);
      by  <= DW'(vert[bary_pkg::REG_VERT2_Y]) - DW'(pt_y);
      dx  <= DW'(pt_x) - DW'(vert[bary_pkg::REG_VERT0_X]);
      dy  <= DW'(pt_y) - DW'(vert[bary_pkg::REG_VERT0_Y]);
    end
  end

  // stage 2: the two products of each cross product
  logic signed [PW-1:0] pa_area, qa_area, pa_a, qa_a, pa_b, qa_b, pa_c, qa_c;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_area <= PW'(e1x) * PW'(e2y);
      qa_area <= PW'(e2x) * PW'(e1y);
      pa_a    <= PW'(ax)  * PW'(by);
      qa_a    <= PW'(bx)  * PW'(ay);
      pa_b    <= PW'(dx)  * PW'(e2y);
      qa_b    <= PW'(e2x) * PW'(dy);
      pa_c    <= PW'(e1x) * PW'(dy);
      qa_c    <= PW'(dx)  * PW'(e1y);
    end
  end

  // stage 3: doubled signed areas
  logic signed [XW-1:0] area;
  logic signed [XW-1:0] sub_area [NL];

  always_ff @(posedge clk) begin
    if (en) begin
      area        <= XW'(pa_area) - XW'(qa_area);
      sub_area[0] <= XW'(pa_a) - XW'(qa_a);
      sub_area[1] <= XW'(pa_b) - XW'(qa_b);
      sub_area[2] <= XW'(pa_c) - XW'(qa_c);
    end
  end

  // divider pipeline registers, entry 0 is the setup stage
  logic [bary_pkg::NUM_W-1:0] div_rem [NS+1][NL];
  logic [NS-1:0]              div_q   [NS+1][NL];
  logic [bary_pkg::DEN_W-1:0] div_den [NS+1];
  logic [NL-1:0]              div_neg [NS+1];
  logic                       div_deg [NS+1];

  // stage 4: magnitudes, rounding offset and divisor
  logic [bary_pkg::MAG_W-1:0] area_mag;
  logic [bary_pkg::MAG_W-1:0] sub_mag [NL];

  always_comb begin
    area_mag = area[XW-1] ? bary_pkg::MAG_W'(-area) : bary_pkg::MAG_W'(area);
    for (int l = 0; l < NL; l++) begin
      sub_mag[l] = sub_area[l][XW-1] ? bary_pkg::MAG_W'(-sub_area[l])
                                     : bary_pkg::MAG_W'(sub_area[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_den[0] <= bary_pkg::DEN_W'(area_mag) << 1;
      div_deg[0] <= (area == '0);
      for (int l = 0; l < NL; l++) begin
        div_rem[0][l] <= (bary_pkg::NUM_W'(sub_mag[l]) << (bary_pkg::WEIGHT_FRAC_BITS + 1))
                         + bary_pkg::NUM_W'(area_mag);
        div_q[0][l]   <= '0;
        div_neg[0][l] <= sub_area[l][XW-1] ^ area[XW-1];
      end
    end
  end

  // restoring divider, one quotient bit per stage, most significant first
  for (genvar k = 1; k <= NS; k++) begin : g_div
    localparam int SHIFT = NS - k;
    logic [bary_pkg::CMP_W-1:0] den_sh;
    logic [bary_pkg::NUM_W-1:0] rem_next [NL];
    logic [NS-1:0]              q_next   [NL];

    assign den_sh = bary_pkg::CMP_W'(div_den[k-1]) << SHIFT;

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [bary_pkg::CMP_W-1:0] rem_ext;
      logic                       ge;
      assign rem_ext     = bary_pkg::CMP_W'(div_rem[k-1][l]);
      assign ge          = rem_ext >= den_sh;
      assign rem_next[l] = ge ? bary_pkg::NUM_W'(rem_ext - den_sh) : div_rem[k-1][l];
      assign q_next[l]   = {div_q[k-1][l][NS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_den[k] <= div_den[k-1];
        div_neg[k] <= div_neg[k-1];
        div_deg[k] <= div_deg[k-1];
        for (int l = 0; l < NL; l++) begin
          div_rem[k][l] <= rem_next[l];
          div_q[k][l]   <= q_next[l];
        end
      end
    end
  end

  // rounding is in the dividend, here only sign and saturation remain
  bary_pkg::result_t fmt_res;

  always_comb begin
    fmt_res.degenerate = div_deg[NS];
    if (div_deg[NS]) begin
      fmt_res.weight_a = '0;
      fmt_res.weight_b = '0;
      fmt_res.weight_c = '0;
    end else begin
      fmt_res.weight_a = bary_pkg::sat_weight(div_q[NS][0], div_neg[NS][0]);
      fmt_res.weight_b = bary_pkg::sat_weight(div_q[NS][1], div_neg[NS][1]);
      fmt_res.weight_c = bary_pkg::sat_weight(div_q[NS][2], div_neg[NS][2]);
    end
  end

  // output register with one skid entry
  bary_pkg::result_t out_res;
  bary_pkg::result_t skid_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!out_vld || m_tready) begin
      if (skid_vld) begin
        out_vld  <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        out_vld <= push;
      end
    end else if (push) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld || m_tready) begin
      if (skid_vld) begin
        out_res <= skid_res;
      end else if (push) begin
        out_res <= fmt_res;
      end
    end else if (push) begin
      skid_res <= fmt_res;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tuser  = out_res.degenerate;
  assign m_tdata  = bary_pkg::M_TDATA_W'({out_res.weight_c, out_res.weight_b,
                                          out_res.weight_a});

  // skid entry only fills behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld)
    else $error("skid entry full while output register empty");

  // degenerate results carry zero weights
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[bary_pkg::OUT_W-1:0] == '0))
    else $error("degenerate result with nonzero weights");

  // a positive quotient in lane a never leaves as a negative weight_a
  a_sign_kept: assert property (@(posedge clk) disable iff (rst)
    (push && !div_deg[NS] && !div_neg[NS][0]) |-> !fmt_res.weight_a[bary_pkg::WEIGHT_BITS-1])
    else $error("positive weight_a came out negative");

  // a stalled pipeline holds its last stage for the next cycle
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_vld && vld[bary_pkg::PIPE_STAGES-1]) |=> vld[bary_pkg::PIPE_STAGES-1])
    else $error("pipeline item dropped during stall");

  // reset empties the pipeline and the output side
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !skid_vld && vld == '0))
    else $error("pipeline not empty after reset");

endmodule
